FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/imu_dfs_pkg.sv
// ----------------------------------------------------------------------------
// IMU frame deframer and scaler package
// Frame codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_dfs_pkg;

	// Frame kinds as reported on the result side
	typedef enum logic [2:0] {
		KIND_ACCEL = 3'd0,
		KIND_GYRO  = 3'd1,
		KIND_ANGLE = 3'd2,
		KIND_MAG   = 3'd3,
		KIND_QUAT  = 3'd4
	} kind_t;

	// Frame bytes
	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_GYRO  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_MAG   = 8'h54;
	localparam logic [7:0] TYPE_QUAT  = 8'h59;

	// Byte positions within a frame
	localparam logic [3:0] POS_HUNT = 4'd0;
	localparam logic [3:0] POS_TYPE = 4'd1;
	localparam logic [3:0] POS_PAY0 = 4'd2;
	localparam logic [3:0] POS_SUM  = 4'd10;

	// Configuration register indexes and reset values
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_ACCEL = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_GYRO  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_ANGLE = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_MAG   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_QUAT  = 3'd4;

	localparam logic [31:0] RST_GAIN_ACCEL = 32'd10276045;
	localparam logic [31:0] RST_GAIN_GYRO  = 32'd2287639;
	localparam logic [31:0] RST_GAIN_ANGLE = 32'd205887;
	localparam logic [31:0] RST_GAIN_MAG   = 32'd2147483648;
	localparam logic [31:0] RST_GAIN_QUAT  = 32'd65536;

	// Temperature divide by 100, floored.
	// With u = raw + 32768, floor(raw*65536/100) equals
	// floor((u*16384 + 13) / 25) - 21474837, and the divide by 25 is a
	// multiply by ceil(2^35/25) and a shift by 35, exact below 2^32.
	localparam logic [29:0] TEMP_BIAS   = 30'd13;
	localparam logic [30:0] RECIP_25    = 31'd1374389535;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam logic [31:0] TEMP_OFFSET = 32'd21474837;

endpackage

`default_nettype wire

FILE: rtl/imu_frame_deframer_scaler_unit.sv
// ----------------------------------------------------------------------------
// IMU frame deframer and scaler
// Hunts 11-byte IMU frames in a byte stream and scales the four payload
// words of each frame to signed Q16.16.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; s_tready only drops when all three result
// stages hold a frame and m_tready is low.
// Result path: the edge that takes the checksum byte captures the frame into stage 1,
// the multiply stage registers the products, and shift/saturate is registered into the output.
// Reset: arst_n clears the frame hunt, the pipeline valids and loads the
// default gains; payload bytes are not reset.
`default_nettype none

module imu_frame_deframer_scaler_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// byte stream in
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [7:0]                           s_tdata,   // [7:0] rx_byte
	// scaled frames out
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [127:0]                         m_tdata,   // [31:0] value_x,
	                                                        // [63:32] value_y,
	                                                        // [95:64] value_z,
	                                                        // [127:96] value_w
	output logic [2:0]                           m_tuser,   // [2:0] frame_kind
	// configuration writes
	input  wire                                  cfg_we,
	input  wire  [imu_dfs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire  [31:0]                          cfg_wdata
);

`include "assert_macros.svh"

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	logic [31:0] gain_accel_q, gain_gyro_q, gain_angle_q, gain_mag_q, gain_quat_q;

	logic [3:0]  byte_pos_q;
	logic [2:0]  kind_q;
	logic [7:0]  payload_q [8];

	logic        in_req;
	logic        sum_req;
	logic        type_ok;
	logic [2:0]  type_kind;
	logic [31:0] gain_sel;

	logic               valid_s1;
	logic signed [15:0] raw_s1 [4];
	logic [31:0]        gain_s1;
	logic [2:0]         kind_s1;

	logic               valid_s2;
	logic signed [48:0] prod_s2 [4];
	logic [25:0]        quo_s2;
	logic signed [15:0] raw_w_s2;
	logic [2:0]         kind_s2;

	logic        ready_s1, ready_s2, ready_out;

	logic [29:0] temp_num;
	logic [60:0] temp_prod;
	logic [31:0] value_w;

	// ------------------------------------------------------------------
	// Floor shift by 15 and saturate to signed 32 bits
	// ------------------------------------------------------------------
	function automatic logic [31:0] scale_sat(input logic signed [48:0] p);
		logic [33:0] sh;
		sh = p[48:15];
		if (sh[33:31] == 3'b000 || sh[33:31] == 3'b111) begin
			return sh[31:0];
		end else if (sh[33]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7FFF_FFFF;
		end
	endfunction

	// ------------------------------------------------------------------
	// Gain registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_accel_q <= imu_dfs_pkg::RST_GAIN_ACCEL;
			gain_gyro_q  <= imu_dfs_pkg::RST_GAIN_GYRO;
			gain_angle_q <= imu_dfs_pkg::RST_GAIN_ANGLE;
			gain_mag_q   <= imu_dfs_pkg::RST_GAIN_MAG;
			gain_quat_q  <= imu_dfs_pkg::RST_GAIN_QUAT;
		end else if (cfg_we) begin
			case (cfg_addr)
				imu_dfs_pkg::REG_GAIN_ACCEL: gain_accel_q <= cfg_wdata;
				imu_dfs_pkg::REG_GAIN_GYRO:  gain_gyro_q  <= cfg_wdata;
				imu_dfs_pkg::REG_GAIN_ANGLE: gain_angle_q <= cfg_wdata;
				imu_dfs_pkg::REG_GAIN_MAG:   gain_mag_q   <= cfg_wdata;
				imu_dfs_pkg::REG_GAIN_QUAT:  gain_quat_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: each stage advances when the one after it has room
	// ------------------------------------------------------------------
	assign ready_out = !m_tvalid || m_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign s_tready  = ready_s1;
	assign in_req    = s_tvalid && s_tready;
	assign sum_req   = in_req && (byte_pos_q >= imu_dfs_pkg::POS_SUM);

	// ------------------------------------------------------------------
	// Decode the type byte
	// ------------------------------------------------------------------
	always_comb begin
		type_ok   = 1'b1;
		type_kind = imu_dfs_pkg::KIND_ACCEL;
		case (s_tdata)
			imu_dfs_pkg::TYPE_ACCEL: type_kind = imu_dfs_pkg::KIND_ACCEL;
			imu_dfs_pkg::TYPE_GYRO:  type_kind = imu_dfs_pkg::KIND_GYRO;
			imu_dfs_pkg::TYPE_ANGLE: type_kind = imu_dfs_pkg::KIND_ANGLE;
			imu_dfs_pkg::TYPE_MAG:   type_kind = imu_dfs_pkg::KIND_MAG;
			imu_dfs_pkg::TYPE_QUAT:  type_kind = imu_dfs_pkg::KIND_QUAT;
			default:                 type_ok   = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// Frame hunt: track byte position and held kind
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= imu_dfs_pkg::POS_HUNT;
			kind_q     <= imu_dfs_pkg::KIND_ACCEL;
		end else if (in_req) begin
			if (byte_pos_q == imu_dfs_pkg::POS_HUNT) begin
				if (s_tdata == imu_dfs_pkg::HDR_BYTE) begin
					byte_pos_q <= imu_dfs_pkg::POS_TYPE;
				end
			end else if (byte_pos_q == imu_dfs_pkg::POS_TYPE) begin
				if (type_ok) begin
					kind_q     <= type_kind;
					byte_pos_q <= imu_dfs_pkg::POS_PAY0;
				end else if (s_tdata == imu_dfs_pkg::HDR_BYTE) begin
					// bad type byte that is itself a header: await type again
					byte_pos_q <= imu_dfs_pkg::POS_TYPE;
				end else begin
					byte_pos_q <= imu_dfs_pkg::POS_HUNT;
				end
			end else if (byte_pos_q < imu_dfs_pkg::POS_SUM) begin
				byte_pos_q <= byte_pos_q + 4'd1;
			end else begin
				byte_pos_q <= imu_dfs_pkg::POS_HUNT;
			end
		end
	end

	// Store payload bytes
	always_ff @(posedge clk) begin
		if (in_req && byte_pos_q >= imu_dfs_pkg::POS_PAY0
				&& byte_pos_q < imu_dfs_pkg::POS_SUM) begin
			payload_q[3'(byte_pos_q - imu_dfs_pkg::POS_PAY0)] <= s_tdata;
		end
	end

	// Pick the gain for the held kind
	always_comb begin
		case (kind_q)
			imu_dfs_pkg::KIND_ACCEL: gain_sel = gain_accel_q;
			imu_dfs_pkg::KIND_GYRO:  gain_sel = gain_gyro_q;
			imu_dfs_pkg::KIND_ANGLE: gain_sel = gain_angle_q;
			imu_dfs_pkg::KIND_MAG:   gain_sel = gain_mag_q;
			default:                 gain_sel = gain_quat_q;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the finished frame on the checksum byte
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sum_req;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sum_req) begin
			for (int k = 0; k < 4; k++) begin
				raw_s1[k] <= {payload_q[2*k+1], payload_q[2*k]};
			end
			gain_s1 <= gain_sel;
			kind_s1 <= kind_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: four gain multiplies and the temperature reciprocal multiply
	// ------------------------------------------------------------------
	assign temp_num  = {raw_s1[3][15] ^ 1'b1, raw_s1[3][14:0], 14'd0}
	                 + imu_dfs_pkg::TEMP_BIAS;
	assign temp_prod = temp_num * imu_dfs_pkg::RECIP_25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= raw_s1[k] * $signed({1'b0, gain_s1});
			end
			quo_s2   <= temp_prod[60:imu_dfs_pkg::RECIP_SHIFT];
			raw_w_s2 <= raw_s1[3];
			kind_s2  <= kind_s1;
		end
	end

	// ------------------------------------------------------------------
	// Output: shift, saturate and select the fourth value
	// ------------------------------------------------------------------
	always_comb begin
		case (kind_s2)
			imu_dfs_pkg::KIND_QUAT:  value_w = scale_sat(prod_s2[3]);
			imu_dfs_pkg::KIND_ANGLE: value_w = {raw_w_s2, 16'd0};
			default:                 value_w = {6'd0, quo_s2} - imu_dfs_pkg::TEMP_OFFSET;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ready_out) begin
			m_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			m_tdata <= {value_w, scale_sat(prod_s2[2]), scale_sat(prod_s2[1]),
			            scale_sat(prod_s2[0])};
			m_tuser <= kind_s2;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_CLK(a_pos_range, byte_pos_q <= imu_dfs_pkg::POS_SUM,
		"byte position beyond checksum")
	`ASSERT_CLK(a_kind_range, kind_q <= imu_dfs_pkg::KIND_QUAT,
		"held frame kind out of range")
	`ASSERT_NEXT(a_sum_capture, sum_req, valid_s1,
		"checksum request did not load stage 1")
	`ASSERT_IMPL(a_stall_full, !s_tready, valid_s1 && valid_s2 && m_tvalid,
		"input stalled with a free result stage")
	`ASSERT_IMPL(a_out_kind, m_tvalid, m_tuser <= imu_dfs_pkg::KIND_QUAT,
		"result kind out of range")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// IMU frame deframer and scaler testbench
// Sends a byte stream through the deframer and checks every scaled frame.
// A short table of hand-picked frames comes first. It covers each frame
// type, the value extremes, saturation, the floor of the gain shift and of
// the temperature divide, a bad type byte, a doubled header and header bytes
// used as payload. Random phases follow, each with new gains. The random
// stream is mostly well-formed frames with random content, plus noise,
// bad type bytes and cut-off frames. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import imu_dfs_pkg::*;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_5 = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BYTES = 155;

	// One scaled frame as seen on the result side
	typedef struct packed {
		kind_t       kind;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [31:0] vw;
	} frame_res_t;

	// One hand-picked frame: optional gain load, up to two lead bytes, frame
	typedef struct packed {
		logic        load;
		logic [31:0] gain;
		logic [1:0]  n_lead;
		logic [7:0]  lead_a;
		logic [7:0]  lead_b;
		logic [7:0]  type_byte;
		logic [15:0] rx;
		logic [15:0] ry;
		logic [15:0] rz;
		logic [15:0] rw;
		logic [7:0]  csum;
		logic        typed;
		kind_t       kind;
		logic [31:0] ex;
		logic [31:0] ey;
		logic [31:0] ez;
		logic [31:0] ew;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] rx_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [127:0]          m_tdata;   // [31:0] value_x, [63:32] value_y,
	                                  // [95:64] value_z, [127:96] value_w
	logic [2:0]            m_tuser;   // [2:0] frame_kind
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [31:0]           cfg_wdata;

	imu_frame_deframer_scaler_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Frame tracker state and gains of the predictor
	logic [3:0]  hunt_pos;
	kind_t       held_kind;
	logic [7:0]  payload [8];
	logic [31:0] gain_q [5];

	frame_res_t  frames_due [$];
	frame_res_t  row_result;
	logic        use_row_result = 1'b0;
	int          fail_count = 0;
	int          burst_left = 0;
	int          bytes_counted = 0;

	// Hand-picked frames; typed results are checked as written
	dir_row_t dir_rows [0:14] = '{
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_ACCEL, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 8'h00, 1'b1, KIND_ACCEL, 32'd0, 32'd0, 32'd0, 32'd0},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_MAG, 16'h0001, 16'hFFFF, 16'h7FFF,
			16'd100, 8'hFF, 1'b1, KIND_MAG, 32'd65536, -32'sd65536, 32'd2147418112,
			32'd65536},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 8'h12, 1'b1, KIND_ANGLE, 32'd0, 32'd0, 32'd0, Q_MIN},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_QUAT, 16'h7FFF, 16'h8000, 16'h0001,
			16'hFFFF, 8'h34, 1'b1, KIND_QUAT, 32'd65534, -32'sd65536, 32'd2, -32'sd2},
		// bad type byte drops the header, then a real frame follows
		'{1'b0, 32'd0, 2'd2, HDR_BYTE, 8'h50, TYPE_GYRO, 16'h5555, 16'h5555, 16'h5555,
			16'h5555, HDR_BYTE, 1'b0, KIND_GYRO, 32'd0, 32'd0, 32'd0, 32'd0},
		// doubled header: the second one is taken as the header again
		'{1'b0, 32'd0, 2'd1, HDR_BYTE, 8'h00, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h1234,
			16'hABCD, 8'hAA, 1'b0, KIND_ACCEL, 32'd0, 32'd0, 32'd0, 32'd0},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_ACCEL, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF, 8'h00, 1'b1, KIND_ACCEL, 32'd0, 32'd0, 32'd0, -32'sd656},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_GYRO, 16'h0000, 16'h0000, 16'h0000,
			16'h7FFF, 8'h00, 1'b1, KIND_GYRO, 32'd0, 32'd0, 32'd0, 32'd21474181},
		// largest gain: saturation both ways and floor of the shift
		'{1'b1, 32'hFFFF_FFFF, 2'd0, 8'h00, 8'h00, TYPE_MAG, 16'h7FFF, 16'h8000,
			16'h0001, 16'hFFFF, 8'h00, 1'b1, KIND_MAG, Q_MAX, Q_MIN, 32'd131071,
			-32'sd656},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_QUAT, 16'hFFFF, 16'h0000, 16'h7FFF,
			16'h8000, 8'h00, 1'b1, KIND_QUAT, -32'sd131072, 32'd0, Q_MAX, Q_MIN},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_ANGLE, 16'h4000, 16'hC000, 16'h0101,
			16'h7FFF, 8'h00, 1'b0, KIND_ANGLE, 32'd0, 32'd0, 32'd0, 32'd0},
		// zero gain
		'{1'b1, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'hFFFF,
			16'h8000, 8'h00, 1'b1, KIND_ACCEL, 32'd0, 32'd0, 32'd0, -32'sd21474837},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'h0001,
			16'h7FFF, 8'h00, 1'b1, KIND_ANGLE, 32'd0, 32'd0, 32'd0, 32'd2147418112},
		// smallest nonzero gain: everything below one floors
		'{1'b1, 32'd1, 2'd0, 8'h00, 8'h00, TYPE_QUAT, 16'h7FFF, 16'h8000, 16'h0001,
			16'hFFFF, 8'h00, 1'b1, KIND_QUAT, 32'd0, -32'sd1, 32'd0, -32'sd1},
		'{1'b0, 32'd0, 2'd0, 8'h00, 8'h00, TYPE_GYRO, 16'h3C5A, 16'h8001, 16'hFFFE,
			16'h00FF, 8'h00, 1'b0, KIND_GYRO, 32'd0, 32'd0, 32'd0, 32'd0}
	};

	function automatic logic [31:0] reset_gain(input logic [CFG_ADDR_W-1:0] idx);
		case (idx)
			REG_GAIN_ACCEL: return RST_GAIN_ACCEL;
			REG_GAIN_GYRO:  return RST_GAIN_GYRO;
			REG_GAIN_ANGLE: return RST_GAIN_ANGLE;
			REG_GAIN_MAG:   return RST_GAIN_MAG;
			default:        return RST_GAIN_QUAT;
		endcase
	endfunction

	function automatic bit type_to_kind(input logic [7:0] b, output kind_t k);
		k = KIND_ACCEL;
		case (b)
			TYPE_ACCEL: k = KIND_ACCEL;
			TYPE_GYRO:  k = KIND_GYRO;
			TYPE_ANGLE: k = KIND_ANGLE;
			TYPE_MAG:   k = KIND_MAG;
			TYPE_QUAT:  k = KIND_QUAT;
			default:    return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < -longint'(Q_MIN))
			return Q_MIN;
		return v[31:0];
	endfunction

	// Signed 16-bit payload word k, little-endian
	function automatic longint word_at(input int k);
		return longint'($signed({payload[2*k+1], payload[2*k]}));
	endfunction

	// (raw * gain) >> 15, floored by the arithmetic shift
	function automatic logic [31:0] gain_scale(input longint raw, input logic [31:0] g);
		longint p;
		p = raw * longint'({32'd0, g});
		return clamp32(p >>> 15);
	endfunction

	function automatic longint floor_div100(input longint p);
		if (p >= 0)
			return p / 100;
		return -((-p + 99) / 100);
	endfunction

	task automatic reset_predictor();
		hunt_pos = POS_HUNT;
		held_kind = KIND_ACCEL;
		for (int i = 0; i < 8; i++)
			payload[i] = 8'h00;
		for (int i = 0; i < 5; i++)
			gain_q[i] = reset_gain(CFG_ADDR_W'(i));
	endtask

	// Advance the frame tracker by one byte; queue a result on the checksum
	task automatic predict_byte(input logic [7:0] b);
		kind_t       k;
		frame_res_t  r;
		logic [31:0] g;
		if (hunt_pos == POS_HUNT) begin
			if (b == HDR_BYTE)
				hunt_pos = POS_TYPE;
		end else if (hunt_pos == POS_TYPE) begin
			if (type_to_kind(b, k)) begin
				held_kind = k;
				hunt_pos = POS_PAY0;
			end else begin
				hunt_pos = (b == HDR_BYTE) ? POS_TYPE : POS_HUNT;
			end
		end else if (hunt_pos < POS_SUM) begin
			payload[3'(hunt_pos - POS_PAY0)] = b;
			hunt_pos = hunt_pos + 4'd1;
		end else begin
			hunt_pos = POS_HUNT;
			g = gain_q[held_kind];
			r.kind = held_kind;
			r.vx = gain_scale(word_at(0), g);
			r.vy = gain_scale(word_at(1), g);
			r.vz = gain_scale(word_at(2), g);
			case (held_kind)
				KIND_QUAT:  r.vw = gain_scale(word_at(3), g);
				KIND_ANGLE: r.vw = clamp32(word_at(3) * 65536);
				default:    r.vw = clamp32(floor_div100(word_at(3) * 65536));
			endcase
			frames_due.push_back(use_row_result ? row_result : r);
		end
	endtask

	// Send one byte request; idle between bursts
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (!(hunt_pos == POS_HUNT && b != HDR_BYTE))
			bytes_counted++;
		predict_byte(b);
		burst_left--;
	endtask

	task automatic send_frame(input logic [7:0] type_byte, input logic [63:0] pay,
			input logic [7:0] csum);
		push_byte(HDR_BYTE);
		push_byte(type_byte);
		for (int i = 0; i < 8; i++)
			push_byte(pay[8*i +: 8]);
		push_byte(csum);
	endtask

	// Hold the input idle until every result is out and the pipe is empty
	task automatic drain_to_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_gain(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_GAIN_QUAT)
			gain_q[idx] = val;
	endtask

	task automatic run_row(input dir_row_t row);
		if (row.load) begin
			drain_to_idle();
			for (int i = REG_GAIN_ACCEL; i <= REG_GAIN_QUAT; i++)
				load_gain(CFG_ADDR_W'(i), row.gain);
		end
		use_row_result = row.typed;
		row_result = '{row.kind, row.ex, row.ey, row.ez, row.ew};
		if (row.n_lead > 2'd0)
			push_byte(row.lead_a);
		if (row.n_lead > 2'd1)
			push_byte(row.lead_b);
		send_frame(row.type_byte, {row.rw, row.rz, row.ry, row.rx}, row.csum);
		use_row_result = 1'b0;
	endtask

	function automatic logic [31:0] pick_gain(input logic [CFG_ADDR_W-1:0] idx);
		case ($urandom_range(5))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return reset_gain(idx);
			3:       return $urandom_range(0, 32'h0002_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(4))
			0:       return TYPE_ACCEL;
			1:       return TYPE_GYRO;
			2:       return TYPE_ANGLE;
			3:       return TYPE_MAG;
			default: return TYPE_QUAT;
		endcase
	endfunction

	// Payload bytes leaning toward the word extremes and the header value
	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			4:       return HDR_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One random piece of stream: mostly whole frames, some noise and breakage
	task automatic random_piece();
		logic [7:0]  t;
		logic [63:0] pay;
		kind_t       k;
		int          n;
		case ($urandom_range(9))
			0: begin
				n = $urandom_range(1, 3);
				repeat (n) push_byte(8'($urandom_range(255)));
			end
			1: begin
				push_byte(HDR_BYTE);
				do t = 8'($urandom_range(255)); while (type_to_kind(t, k));
				push_byte(t);
			end
			2: begin
				// cut-off frame: later bytes fill the rest of it
				push_byte(HDR_BYTE);
				push_byte(pick_type());
				n = $urandom_range(7);
				repeat (n) push_byte(pick_data_byte());
			end
			default: begin
				if ($urandom_range(3) == 0)
					push_byte(HDR_BYTE);
				for (int i = 0; i < 8; i++)
					pay[8*i +: 8] = pick_data_byte();
				send_frame(pick_type(), pay, 8'($urandom_range(255)));
			end
		endcase
	endtask

	// Stimulus
	initial begin
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		cfg_we = 1'b0;
		cfg_addr = REG_GAIN_ACCEL;
		cfg_wdata = 32'd0;
		reset_predictor();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(dir_rows); i++)
			run_row(dir_rows[i]);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_to_idle();
			for (int i = REG_GAIN_ACCEL; i <= REG_GAIN_QUAT; i++)
				load_gain(CFG_ADDR_W'(i), pick_gain(CFG_ADDR_W'(i)));
			// writes beyond the last register must change nothing
			if (ph == 0 || $urandom_range(1) == 0)
				load_gain(($urandom_range(1) == 0) ? REG_SPARE_5 : REG_SPARE_7, $urandom());
			bytes_counted = 0;
			while (bytes_counted < PHASE_BYTES)
				random_piece();
		end

		drain_to_idle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver stall pattern: the ready rate is redrawn each time its pattern runs out
	int unsigned ready_pct = 100;
	int unsigned pattern_left = 0;

	always @(posedge clk) begin
		if (pattern_left == 0) begin
			case ($urandom_range(3))
				0:       ready_pct = 100;
				1:       ready_pct = 75;
				2:       ready_pct = 40;
				default: ready_pct = 8;
			endcase
			pattern_left = $urandom_range(20, 200);
		end else begin
			pattern_left--;
		end
		m_tready <= ($urandom_range(99) < ready_pct);
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
			fail_count++;
		end
	endtask

	// Compare each result request with the oldest frame due
	always @(posedge clk) begin
		frame_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				$error("result with no frame due, kind %0d", m_tuser);
				fail_count++;
			end else begin
				e = frames_due.pop_front();
				check_field("frame_kind", 32'(e.kind), 32'(m_tuser));
				check_field("value_x", e.vx, m_tdata[31:0]);
				check_field("value_y", e.vy, m_tdata[63:32]);
				check_field("value_z", e.vz, m_tdata[95:64]);
				check_field("value_w", e.vw, m_tdata[127:96]);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/imu_dfs_pkg.sv
rtl/imu_frame_deframer_scaler_unit.sv
sim/tb_top.sv
